>>> rtl/crc32tc_pkg.sv
// crc32tc_pkg: constants, result type and the byte-wide crc-32 update
// shared by the trailer checker modules; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package crc32tc_pkg;

    localparam int COUNT_W = 4;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [COUNT_W-1:0] MIN_FILE_BYTES = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] TRAILER_BYTES  = COUNT_W'(4);

    typedef struct packed {
        logic [31:0] crc_value;
        logic [31:0] stored_value;
        logic        has_checksum;
        logic        checksum_ok;
    } result_t;

    // reflected crc-32, one byte, lsb first
    function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/crc32tc_track.sv
// crc32tc_track: per-file state (crc, four-byte delay line, byte count)
// and the result of a file end; uses crc32tc_pkg
`timescale 1ns / 1ps
`default_nettype none

module crc32tc_track
    import crc32tc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] byte_value,
    input  wire logic       last_byte,
    output result_t         result
);

    logic [31:0]        crc_reg;
    logic [31:0]        crc_next;
    logic [31:0]        tail_reg;
    logic [31:0]        tail_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic [31:0]        crc_upd;
    logic [31:0]        tail_upd;
    logic [COUNT_W-1:0] count_upd;
    logic               has;

    always_comb
    begin
        // oldest held byte leaves the delay line into the crc
        crc_upd   = (count_reg >= TRAILER_BYTES) ? crc_feed(crc_reg, tail_reg[7:0]) : crc_reg;
        tail_upd  = {byte_value, tail_reg[31:8]};
        count_upd = (count_reg < MIN_FILE_BYTES) ? count_reg + COUNT_W'(1) : count_reg;
        has       = (count_upd >= MIN_FILE_BYTES);

        result.has_checksum = has;
        result.crc_value    = has ? ~crc_upd : 32'h0;
        result.stored_value = has ? tail_upd : 32'h0;
        result.checksum_ok  = !has || (~crc_upd == tail_upd);

        crc_next   = crc_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (take)
        begin
            if (last_byte)
            begin
                crc_next   = CRC_INIT;
                tail_next  = 32'h0;
                count_next = '0;
            end
            else
            begin
                crc_next   = crc_upd;
                tail_next  = tail_upd;
                count_next = count_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            tail_reg  <= 32'h0;
            count_reg <= '0;
        end
        else
        begin
            crc_reg   <= crc_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/crc32tc_outreg.sv
// crc32tc_outreg: result register on the output channel, holds a request
// while the receiver stalls; uses crc32tc_pkg
`timescale 1ns / 1ps
`default_nettype none

module crc32tc_outreg
    import crc32tc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t data,
    input  wire logic    out_stall,
    output logic         busy,
    output logic         out_valid,
    output result_t      held
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;
    result_t data_next;

    always_comb
    begin
        busy       = valid_reg && out_stall;
        valid_next = valid_reg && out_stall;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign held      = data_reg;

endmodule

`default_nettype wire

>>> rtl/crc32_trailer_checker.sv
// crc32_trailer_checker: top level of the crc-32 trailer checker
// uses crc32tc_pkg, crc32tc_track and crc32tc_outreg
//
// a file enters one byte per request on the input channel (byte_value,
// last_byte); last_byte marks its final byte. the crc-32 runs over all
// bytes but the final four, which are read as a little-endian trailer.
// one request leaves on the output channel per file, in the cycle after the
// final byte is taken: crc_value, stored_value, has_checksum, checksum_ok.
// files under eight bytes give zero crc and trailer, has_checksum low and
// checksum_ok high.
// throughput: one byte per cycle while in_stall is low; the byte-wide crc
// update and the trailer compare sit between the state and result registers.
// in_stall rises only while a result is held and out_stall is high; the
// held result stays unchanged until taken.
// reset clears the crc to all ones, the delay line and the byte count and
// drops out_valid; every final byte clears the crc, delay line and count.
`timescale 1ns / 1ps
`default_nettype none

module crc32_trailer_checker
    import crc32tc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  byte_value,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      crc_value,
    output logic [31:0]      stored_value,
    output logic             has_checksum,
    output logic             checksum_ok
);

    logic    take;
    logic    busy;
    result_t result;
    result_t held;

    assign take     = in_valid && !busy;
    assign in_stall = busy;

    crc32tc_track u_track
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .byte_value (byte_value),
        .last_byte  (last_byte),
        .result     (result)
    );

    crc32tc_outreg u_outreg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && last_byte),
        .data      (result),
        .out_stall (out_stall),
        .busy      (busy),
        .out_valid (out_valid),
        .held      (held)
    );

    assign crc_value    = held.crc_value;
    assign stored_value = held.stored_value;
    assign has_checksum = held.has_checksum;
    assign checksum_ok  = held.checksum_ok;

    // short file reports fixed fields
    a_short_file: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_checksum |-> crc_value == 32'h0 && stored_value == 32'h0 && checksum_ok)
        else $error("short file result fields wrong");

    // verdict agrees with the reported values
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_checksum |-> checksum_ok == (crc_value == stored_value))
        else $error("checksum_ok disagrees with crc and trailer");

    // a taken final byte yields a result next cycle
    a_final_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_byte |=> out_valid)
        else $error("no result after final byte");

endmodule

`default_nettype wire

>>> sim/crc32_trailer_checker_test.sv
// crc32_trailer_checker_test: self-checking bench for the crc-32 trailer checker,
// a directed table of short and boundary files followed by random files
// depends on crc32tc_pkg (result_t) and crc32_trailer_checker
`timescale 1ns / 1ps

module crc32_trailer_checker_test;

    import crc32tc_pkg::result_t;

    localparam logic [31:0] CRC_SEED       = 32'hFFFF_FFFF;
    localparam logic [31:0] REFLECTED_POLY = 32'hEDB8_8320;
    localparam logic [3:0]  TRAILER_LEN    = 4'd4;
    localparam logic [3:0]  CHECKED_LEN    = 4'd8;

    localparam int RANDOM_BYTES  = 800;
    localparam int DIRECTED_ROWS = 24;
    localparam int CALM_MARK     = DIRECTED_ROWS + RANDOM_BYTES - 120;
    localparam int HOLD_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 100000;

    localparam result_t NO_VERDICT    = '0;
    localparam result_t SHORT_FILE    = {32'h0, 32'h0, 1'b0, 1'b1};
    localparam result_t ZERO_BODY     = {32'h2144_DF1C, 32'h2144_DF1C, 1'b1, 1'b1};
    localparam result_t ONES_BODY_BAD = {32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0};

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       pinned;
        result_t    verdict;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
        // one-byte file
        {8'hFF, 1'b1, 1'b1, SHORT_FILE},
        // seven-byte file, just short of a checksum
        {8'h00, 1'b0, 1'b0, NO_VERDICT},
        {8'hFF, 1'b0, 1'b0, NO_VERDICT},
        {8'h80, 1'b0, 1'b0, NO_VERDICT},
        {8'h01, 1'b0, 1'b0, NO_VERDICT},
        {8'h7F, 1'b0, 1'b0, NO_VERDICT},
        {8'hFE, 1'b0, 1'b0, NO_VERDICT},
        {8'hAA, 1'b1, 1'b1, SHORT_FILE},
        // four zero bytes with their own crc as trailer
        {8'h00, 1'b0, 1'b0, NO_VERDICT},
        {8'h00, 1'b0, 1'b0, NO_VERDICT},
        {8'h00, 1'b0, 1'b0, NO_VERDICT},
        {8'h00, 1'b0, 1'b0, NO_VERDICT},
        {8'h1C, 1'b0, 1'b0, NO_VERDICT},
        {8'hDF, 1'b0, 1'b0, NO_VERDICT},
        {8'h44, 1'b0, 1'b0, NO_VERDICT},
        {8'h21, 1'b1, 1'b1, ZERO_BODY},
        // four all-ones bytes with a wrong all-zero trailer
        {8'hFF, 1'b0, 1'b0, NO_VERDICT},
        {8'hFF, 1'b0, 1'b0, NO_VERDICT},
        {8'hFF, 1'b0, 1'b0, NO_VERDICT},
        {8'hFF, 1'b0, 1'b0, NO_VERDICT},
        {8'h00, 1'b0, 1'b0, NO_VERDICT},
        {8'h00, 1'b0, 1'b0, NO_VERDICT},
        {8'h00, 1'b0, 1'b0, NO_VERDICT},
        {8'h00, 1'b1, 1'b1, ONES_BODY_BAD}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  byte_value = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] crc_value;
    logic [31:0] stored_value;
    logic        has_checksum;
    logic        checksum_ok;

    // predictor state for the file in flight
    logic [31:0]      crc_acc = CRC_SEED;
    logic [3:0][7:0]  tail_window = '0;
    logic [3:0]       file_bytes_seen = '0;

    result_t pending_verdicts [$];
    logic    pin_active = 1'b0;
    result_t pin_verdict = '0;
    logic    hold_request = 1'b0;
    logic    calm = 1'b0;
    int      bytes_sent = 0;
    int      cycle_count = 0;
    int      mismatch_count = 0;

    crc32_trailer_checker uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_value   (byte_value),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .crc_value    (crc_value),
        .stored_value (stored_value),
        .has_checksum (has_checksum),
        .checksum_ok  (checksum_ok)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] data);
        logic [31:0] r;
        r = acc ^ {24'd0, data};
        repeat (8)
            r = {1'b0, r[31:1]} ^ (r[0] ? REFLECTED_POLY : 32'd0);
        return r;
    endfunction

    task automatic offer_byte(input logic [7:0] data, input logic fin, input logic pinned,
                              input result_t verdict);
        if (!calm && (bytes_sent / 60) % 3 != 1 && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        pin_active = pinned;
        pin_verdict = verdict;
        in_valid <= 1'b1;
        byte_value <= data;
        last_byte <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
        calm = bytes_sent >= CALM_MARK;
    endtask

    task automatic settle_until_drained();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result check first, then the request taken at this edge
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: crc %h stored %h has %b ok %b",
                                 crc_value, stored_value, has_checksum, checksum_ok);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (crc_value !== want.crc_value || stored_value !== want.stored_value ||
                        has_checksum !== want.has_checksum ||
                        checksum_ok !== want.checksum_ok)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: crc %h/%h stored %h/%h has %b/%b ok %b/%b",
                                     want.crc_value, crc_value, want.stored_value,
                                     stored_value, want.has_checksum, has_checksum,
                                     want.checksum_ok, checksum_ok);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (file_bytes_seen >= TRAILER_LEN)
                    crc_acc = crc32_step(crc_acc, tail_window[0]);
                tail_window = {byte_value, tail_window[3:1]};
                if (file_bytes_seen < CHECKED_LEN)
                    file_bytes_seen++;
                if (last_byte)
                begin
                    if (file_bytes_seen == CHECKED_LEN)
                        want = {~crc_acc, tail_window, 1'b1, ~crc_acc == tail_window};
                    else
                        want = SHORT_FILE;
                    if (pin_active)
                        want = pin_verdict;
                    pending_verdicts.push_back(want);
                    crc_acc = CRC_SEED;
                    tail_window = '0;
                    file_bytes_seen = '0;
                end
            end
        end
    end

    // receiver: short random stall bursts, one long hold-off on request
    initial
    begin
        int hold_left;
        int burst_left;
        hold_left = 0;
        burst_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (burst_left == 0 && !calm && (cycle_count / 150) % 3 != 0 &&
                $urandom_range(0, 5) == 0)
                burst_left = $urandom_range(1, 4);
            out_stall <= (hold_left != 0) || (burst_left != 0);
            if (hold_left != 0)
                hold_left--;
            if (burst_left != 0)
                burst_left--;
        end
    end

    initial
    begin
        int          files_sent;
        int          kind;
        int          body_len;
        logic [31:0] body_crc;
        logic [31:0] trailer;
        logic [7:0]  file_q [$];
        files_sent = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (DIRECTED[i])
            offer_byte(DIRECTED[i].data, DIRECTED[i].fin, DIRECTED[i].pinned,
                       DIRECTED[i].verdict);
        settle_until_drained();
        while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES)
        begin
            if (files_sent == 8)
                hold_request = 1'b1;
            if (files_sent == 20)
                settle_until_drained();
            file_q.delete();
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                body_len = $urandom_range(1, 7);
                repeat (body_len)
                    file_q.push_back(8'($urandom));
            end
            else
            begin
                body_len = (kind == 9) ? $urandom_range(21, 90) : $urandom_range(4, 20);
                body_crc = CRC_SEED;
                repeat (body_len)
                begin
                    file_q.push_back(8'($urandom));
                    body_crc = crc32_step(body_crc, file_q[$]);
                end
                trailer = ~body_crc;
                // corrupt trailers: one flipped bit, or random
                if (kind == 1)
                    trailer = trailer ^ (32'd1 << $urandom_range(0, 31));
                if (kind == 2)
                    trailer = $urandom;
                for (int k = 0; k < 4; k++)
                    file_q.push_back(trailer[8*k +: 8]);
            end
            foreach (file_q[k])
                offer_byte(file_q[k], k == file_q.size() - 1, 1'b0, NO_VERDICT);
            files_sent++;
        end
        settle_until_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
